/* design/string_escape_decoder_macros.svh */
// Assertion macros shared by the string escape decoder modules.
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SED_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sed_pkg.sv */
// Types, constants and helper functions of the string escape decoder.
package sed_pkg;

    // Decoder modes.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_OCTAL  = 2'd3;

    // Digit limits.
    localparam logic [2:0] HEX_MAX_DIGITS = 3'd4;
    localparam logic [2:0] OCT_MAX_DIGITS = 3'd3;

    // Characters with a meaning in an escape.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    // Control bytes produced by escapes.
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // Default depth of the command queue.
    localparam int SED_QUEUE_DEPTH = 4;

    // Most decoded bytes that one input byte can cause.
    localparam int MAX_BYTES = 3;

    // One queued command: up to three decoded bytes for one input beat.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [1:0]                count;
        logic                      str_end;
    } cmd_t;

    // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                d = b - CH_ZERO;
                return {1'b1, d[3:0]};
            end
            else if (b >= CH_LOWER_A && b <= CH_LOWER_F)
            begin
                d = b - CH_LOWER_A + 8'd10;
                return {1'b1, d[3:0]};
            end
            else if (b >= CH_UPPER_A && b <= CH_UPPER_F)
            begin
                d = b - CH_UPPER_A + 8'd10;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

endpackage

/* design/string_escape_decoder.sv */
// Top level of the string escape decoder.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------
//   source  | src_valid | src_stall | in_byte, string_end
//   result  | dst_valid | dst_stall | out_byte, run_last, string_last
//
// The front end takes one input beat per cycle unless src_stall is high and
// decodes it in that cycle; the queue registers the command. The back end
// gives one result beat per cycle unless dst_stall is high. An input that
// yields two or three bytes holds it for each byte, absorbed by the queue.
// src_stall is high only while the command queue is full.
// Reset returns the decoder to normal mode and empties the queue.
module string_escape_decoder
    import sed_pkg::*;
#(
    parameter int QUEUE_DEPTH = SED_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_last
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    sed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .in_byte    (in_byte),
        .string_end (string_end),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    sed_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .head        (head_cmd),
        .pop         (pop),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule

/* design/sed_front.sv */
// Front end: accepts raw bytes, tracks escape state and builds byte commands.
module sed_front
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] val_reg, val_next;

    logic        accept;
    logic [4:0]  hex_d;
    logic        is_oct;
    logic [2:0]  nc;
    logic [15:0] nv_hex;
    logic [15:0] nv_oct;
    logic [1:0]  n;
    logic [MAX_BYTES-1:0][7:0] bytes;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    assign hex_d  = hex_digit(in_byte);
    assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    assign nc     = cnt_reg + 3'd1;
    assign nv_hex = {val_reg[11:0], hex_d[3:0]};
    assign nv_oct = {val_reg[12:0], in_byte[2:0]};

    // Decode one byte into up to three output bytes and the next state.
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        n         = 2'd0;
        bytes     = '0;
        case (mode_reg)
            MODE_ESCAPE:
            begin
                mode_next = MODE_NORMAL;
                if (in_byte == CH_N)
                begin
                    bytes[n] = BYTE_LF;
                    n = n + 2'd1;
                end
                else if (in_byte == CH_R)
                begin
                    bytes[n] = BYTE_CR;
                    n = n + 2'd1;
                end
                else if (in_byte == CH_T)
                begin
                    bytes[n] = BYTE_TAB;
                    n = n + 2'd1;
                end
                else if (in_byte == CH_X)
                begin
                    cnt_next = 3'd0;
                    val_next = 16'd0;
                    if (string_end)
                    begin
                        bytes[n] = CH_X;
                        n = n + 2'd1;
                    end
                    else
                    begin
                        mode_next = MODE_HEX;
                    end
                end
                else if (is_oct)
                begin
                    mode_next = MODE_OCTAL;
                    cnt_next  = 3'd1;
                    val_next  = {13'd0, in_byte[2:0]};
                    if (string_end)
                    begin
                        bytes[n] = {5'd0, in_byte[2:0]};
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    bytes[n] = in_byte;
                    n = n + 2'd1;
                end
            end
            MODE_HEX:
            begin
                if (hex_d[4])
                begin
                    if (nc >= HEX_MAX_DIGITS || string_end)
                    begin
                        // Flush with the new digit included.
                        if (nc > 3'd2)
                        begin
                            bytes[n] = nv_hex[15:8];
                            n = n + 2'd1;
                        end
                        bytes[n] = nv_hex[7:0];
                        n = n + 2'd1;
                        mode_next = MODE_NORMAL;
                        cnt_next  = 3'd0;
                        val_next  = 16'd0;
                    end
                    else
                    begin
                        cnt_next = nc;
                        val_next = nv_hex;
                    end
                end
                else
                begin
                    // Flush pending digits, then treat the byte as plain.
                    if (cnt_reg == 3'd0)
                    begin
                        bytes[n] = CH_X;
                        n = n + 2'd1;
                    end
                    else if (cnt_reg > 3'd2)
                    begin
                        bytes[n] = val_reg[15:8];
                        n = n + 2'd1;
                        bytes[n] = val_reg[7:0];
                        n = n + 2'd1;
                    end
                    else
                    begin
                        bytes[n] = val_reg[7:0];
                        n = n + 2'd1;
                    end
                    mode_next = MODE_NORMAL;
                    cnt_next  = 3'd0;
                    val_next  = 16'd0;
                    if (in_byte == CH_BACKSLASH && !string_end)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        bytes[n] = in_byte;
                        n = n + 2'd1;
                    end
                end
            end
            MODE_OCTAL:
            begin
                if (is_oct)
                begin
                    if (nc >= OCT_MAX_DIGITS || string_end)
                    begin
                        bytes[n] = nv_oct[7:0];
                        n = n + 2'd1;
                        mode_next = MODE_NORMAL;
                        cnt_next  = 3'd0;
                        val_next  = 16'd0;
                    end
                    else
                    begin
                        cnt_next = nc;
                        val_next = nv_oct;
                    end
                end
                else
                begin
                    bytes[n] = val_reg[7:0];
                    n = n + 2'd1;
                    mode_next = MODE_NORMAL;
                    cnt_next  = 3'd0;
                    val_next  = 16'd0;
                    if (in_byte == CH_BACKSLASH && !string_end)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        bytes[n] = in_byte;
                        n = n + 2'd1;
                    end
                end
            end
            default:
            begin
                if (in_byte == CH_BACKSLASH && !string_end)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    bytes[n] = in_byte;
                    n = n + 2'd1;
                end
            end
        endcase
        // The end of a string always returns to a clean state.
        if (string_end)
        begin
            mode_next = MODE_NORMAL;
            cnt_next  = 3'd0;
            val_next  = 16'd0;
        end
    end

    // Push a command whenever the beat produces at least one byte.
    assign push             = accept && (n != 2'd0);
    assign push_cmd.data    = bytes;
    assign push_cmd.count   = n;
    assign push_cmd.str_end = string_end;

    // Escape state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 3'd0;
            val_reg  <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            val_reg  <= val_next;
        end
    end

endmodule

/* design/sed_queue.sv */
// Short command queue between the front end and the back end.
module sed_queue
    import sed_pkg::*;
#(
    parameter int DEPTH = SED_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    `include "string_escape_decoder_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SED_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !full, "push into a full queue")
    `SED_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from an empty queue")
    `SED_ASSERT_NEXT(a_fill_tracks, clk, rst_n, push && !pop, cnt_reg != '0, "fill count lost a push")
    `SED_ASSERT_SAME(a_cmd_nonempty, clk, rst_n, push, push_cmd.count != 2'd0, "empty command queued")

endmodule

/* design/sed_back.sv */
// Back end: plays out the bytes of each queued command, one beat per byte.
module sed_back
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  cmd_t       head,
    output logic       pop,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_last
);

    `include "string_escape_decoder_macros.svh"

    logic [1:0] idx_reg, idx_next;
    logic       take;

    // Present the selected byte of the head command.
    assign dst_valid   = !empty;
    assign out_byte    = head.data[idx_reg];
    assign run_last    = (idx_reg == head.count - 2'd1);
    assign string_last = run_last && head.str_end;
    assign take        = dst_valid && !dst_stall;
    assign pop         = take && run_last;

    // Byte index within the head command.
    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    `SED_ASSERT_SAME(a_idx_in_cmd, clk, rst_n, dst_valid, idx_reg < head.count, "byte index past command")

endmodule

/* sim/string_escape_decoder_tb.sv */
// Self-checking testbench for the string escape decoder.
`timescale 1ns / 1ps

module string_escape_decoder_tb
    import sed_pkg::*;
();

    localparam int          TOTAL_BEATS    = 360;
    localparam int          CALM_AFTER     = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_REPORTS    = 40;
    localparam logic [7:0]  CH_QUOTE       = 8'h22;

    // One decoded byte as the result channel carries it.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_last;
    } dec_byte_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       src_valid;
    logic       src_stall;
    logic [7:0] in_byte;
    logic       string_end;
    logic       dst_valid;
    logic       dst_stall;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    // Shadow of the decoder state.
    logic [1:0]  dec_mode;
    logic [2:0]  dig_count;
    logic [15:0] dig_value;

    dec_byte_t  expected_q[$];
    logic [7:0] step_bytes[$];
    logic [7:0] str_bytes[$];

    bit quiet = 1'b0;
    int beats_sent = 0;
    int strings_sent = 0;
    int bytes_checked = 0;
    int error_count = 0;
    int idle_cycles = 0;

    string_escape_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .in_byte     (in_byte),
        .string_end  (string_end),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

    always #5 clk = ~clk;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                d = b - CH_ZERO;
                return {1'b1, d[3:0]};
            end
            if (b >= CH_LOWER_A && b <= CH_LOWER_F)
            begin
                d = b - CH_LOWER_A + 8'd10;
                return {1'b1, d[3:0]};
            end
            if (b >= CH_UPPER_A && b <= CH_UPPER_F)
            begin
                d = b - CH_UPPER_A + 8'd10;
                return {1'b1, d[3:0]};
            end
            return 5'd0;
        end
    endfunction

    task clear_digits;
        begin
            dec_mode  = MODE_NORMAL;
            dig_count = 3'd0;
            dig_value = 16'd0;
        end
    endtask

    // Pending hex digits: none gives a literal x, three or four give two bytes.
    task flush_hex;
        begin
            if (dig_count == 3'd0)
                step_bytes = {step_bytes, CH_X};
            else if (dig_count > 3'd2)
            begin
                step_bytes = {step_bytes, dig_value[15:8]};
                step_bytes = {step_bytes, dig_value[7:0]};
            end
            else
                step_bytes = {step_bytes, dig_value[7:0]};
            clear_digits();
        end
    endtask

    task flush_octal;
        begin
            step_bytes = {step_bytes, dig_value[7:0]};
            clear_digits();
        end
    endtask

    // A backslash opens an escape unless it is the final byte of the string.
    task plain_byte(input logic [7:0] b, input logic last);
        begin
            if (b == CH_BACKSLASH && !last)
                dec_mode = MODE_ESCAPE;
            else
                step_bytes = {step_bytes, b};
        end
    endtask

    // Works out the decoded bytes of one accepted beat and queues them.
    task decode_beat(input logic [7:0] b, input logic last);
        logic [4:0] nib;
        dec_byte_t  r;
        begin
            step_bytes.delete();
            case (dec_mode)
                MODE_ESCAPE:
                begin
                    dec_mode = MODE_NORMAL;
                    if (b == CH_N)
                        step_bytes = {step_bytes, BYTE_LF};
                    else if (b == CH_R)
                        step_bytes = {step_bytes, BYTE_CR};
                    else if (b == CH_T)
                        step_bytes = {step_bytes, BYTE_TAB};
                    else if (b == CH_X)
                    begin
                        dig_count = 3'd0;
                        dig_value = 16'd0;
                        if (last)
                            step_bytes = {step_bytes, CH_X};
                        else
                            dec_mode = MODE_HEX;
                    end
                    else if (b >= CH_ZERO && b <= CH_SEVEN)
                    begin
                        dec_mode  = MODE_OCTAL;
                        dig_count = 3'd1;
                        dig_value = {13'd0, b[2:0]};
                        if (last)
                            flush_octal();
                    end
                    else
                        step_bytes = {step_bytes, b};
                end
                MODE_HEX:
                begin
                    nib = hex_nibble(b);
                    if (nib[4])
                    begin
                        dig_value = {dig_value[11:0], nib[3:0]};
                        dig_count = dig_count + 3'd1;
                        if (dig_count >= HEX_MAX_DIGITS || last)
                            flush_hex();
                    end
                    else
                    begin
                        flush_hex();
                        plain_byte(b, last);
                    end
                end
                MODE_OCTAL:
                begin
                    if (b >= CH_ZERO && b <= CH_SEVEN)
                    begin
                        dig_value = {dig_value[12:0], b[2:0]};
                        dig_count = dig_count + 3'd1;
                        if (dig_count >= OCT_MAX_DIGITS || last)
                            flush_octal();
                    end
                    else
                    begin
                        flush_octal();
                        plain_byte(b, last);
                    end
                end
                default:
                    plain_byte(b, last);
            endcase
            if (last)
                clear_digits();

            // Flag the final byte of the beat and, on the last beat, of the string.
            foreach (step_bytes[i])
            begin
                r.data        = step_bytes[i];
                r.run_last    = (i == step_bytes.size() - 1);
                r.string_last = r.run_last && last;
                expected_q = {expected_q, r};
            end
        end
    endtask

    // Sends one beat, with an occasional gap ahead of it, and waits for acceptance.
    task send_beat(input logic [7:0] b, input logic last);
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                src_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            src_valid  <= 1'b1;
            in_byte    <= b;
            string_end <= last;
            @(posedge clk);
            while (src_stall)
                @(posedge clk);
            decode_beat(b, last);
            beats_sent++;
        end
    endtask

    // Sends the bytes in str_bytes as one string, marking the final byte.
    task send_bytes;
        begin
            foreach (str_bytes[i])
                send_beat(str_bytes[i], i == str_bytes.size() - 1);
            strings_sent++;
        end
    endtask

    task send_text(input string s);
        begin
            str_bytes.delete();
            for (int i = 0; i < s.len(); i++)
                str_bytes = {str_bytes, 8'(s[i])};
            send_bytes();
        end
    endtask

    // Extreme byte values, including bytes above 0x7F, pass through unchanged.
    task test_plain_bytes;
        begin
            str_bytes = '{8'h00, 8'hFF, 8'h80};
            send_bytes();
        end
    endtask

    // Control escapes, self escapes and an unknown escape on the digit 9.
    task test_simple_escapes;
        begin
            send_text("\\n\\r\\t\\\\\\\"\\9");
        end
    endtask

    // Hex flushed by a non-digit, hex at its digit limit, and x at the end.
    task test_hex_escapes;
        begin
            send_text("\\x123g");
            send_text("\\xABCD\\x");
        end
    endtask

    // Bare x before a new escape, octal at its limit, octal flushed by the
    // end of the string, and a trailing backslash.
    task test_octal_escapes;
        begin
            send_text("\\x\\777\\");
            send_text("\\5\\12");
        end
    endtask

    // Random strings built mostly from well-formed escapes with random content.
    task test_random_strings;
        string      edge_chars;
        int         ntok;
        int         kind;
        int         ndig;
        int         v;
        logic [7:0] c;
        begin
            edge_chars = "89gG/:@`xF";
            while (beats_sent < TOTAL_BEATS)
            begin
                if (beats_sent >= CALM_AFTER)
                    quiet = 1'b1;
                str_bytes.delete();
                ntok = $urandom_range(1, 5);
                for (int t = 0; t < ntok; t++)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind <= 2)
                        str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
                    else if (kind <= 4)
                    begin
                        str_bytes = {str_bytes, CH_BACKSLASH};
                        case ($urandom_range(0, 5))
                            0: c = CH_N;
                            1: c = CH_R;
                            2: c = CH_T;
                            3: c = CH_BACKSLASH;
                            4: c = CH_QUOTE;
                            default: c = 8'($urandom_range(0, 255));
                        endcase
                        str_bytes = {str_bytes, c};
                    end
                    else if (kind <= 6)
                    begin
                        str_bytes = {str_bytes, CH_BACKSLASH};
                        str_bytes = {str_bytes, CH_X};
                        ndig = $urandom_range(0, 5);
                        for (int k = 0; k < ndig; k++)
                        begin
                            v = $urandom_range(0, 15);
                            if (v < 10)
                                c = 8'(CH_ZERO + v);
                            else if ($urandom_range(0, 1) == 0)
                                c = 8'(CH_LOWER_A + v - 10);
                            else
                                c = 8'(CH_UPPER_A + v - 10);
                            str_bytes = {str_bytes, c};
                        end
                    end
                    else if (kind <= 8)
                    begin
                        str_bytes = {str_bytes, CH_BACKSLASH};
                        ndig = $urandom_range(1, 4);
                        for (int k = 0; k < ndig; k++)
                            str_bytes = {str_bytes, 8'(CH_ZERO + $urandom_range(0, 7))};
                    end
                    else
                        str_bytes = {str_bytes,
                                     edge_chars[$urandom_range(0, edge_chars.len() - 1)]};
                end
                send_bytes();
            end
        end
    endtask

    // Result side stalls in random bursts until the calm tail of the run.
    initial
    begin : result_sink
        dst_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !quiet && $urandom_range(0, 7) == 0)
            begin
                dst_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                dst_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result beat with the oldest expected byte.
    always @(posedge clk)
    begin : result_check
        dec_byte_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, out_byte);
            end
            else
            begin
                want = expected_q.pop_front();
                bytes_checked++;
                if (out_byte !== want.data)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: out_byte expected %h, actual %h",
                                 $time, want.data, out_byte);
                end
                if (run_last !== want.run_last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: run_last expected %b, actual %b",
                                 $time, want.run_last, run_last);
                end
                if (string_last !== want.string_last)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: string_last expected %b, actual %b",
                                 $time, want.string_last, string_last);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        src_valid  <= 1'b0;
        in_byte    <= 8'h00;
        string_end <= 1'b0;
        clear_digits();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_simple_escapes();
        test_hex_escapes();
        test_octal_escapes();
        test_random_strings();

        // Drop valid right after the last accepted beat, then drain the result side.
        src_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d input beats in %0d strings; %0d decoded bytes were checked.",
                 beats_sent, strings_sent, bytes_checked);
        $display("Stimulus covered control, hex, octal and unknown escapes with random stalls.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sed_pkg.sv
design/sed_front.sv
design/sed_queue.sv
design/sed_back.sv
design/string_escape_decoder.sv
sim/string_escape_decoder_tb.sv
